// ----- hw/rtl/mfau_pkg.sv -----
// Package with shared widths, opcodes and the controller-to-datapath command types.
`default_nettype none
package mfau_pkg;
    localparam int PartWidthDefault = 16;
    localparam int FieldWidth       = 16;
    localparam int ValWidth         = 32;
    localparam int ProdWidth        = 62;
    localparam int WholeWidth       = 64;
    localparam int FracWidth        = 48;
    localparam int CntWidth         = 6;

    typedef enum logic [1:0] {
        CMD_MUL = 2'd0,
        CMD_DIV = 2'd1,
        CMD_CMP = 2'd2,
        CMD_RSV = 2'd3
    } t_cmd;

    localparam logic [1:0] ORDER_LESS    = 2'd0;
    localparam logic [1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [1:0] ORDER_GREATER = 2'd2;

    typedef struct packed {
        logic load;       // capture and sign-extend operands, load the multiplier
        logic mul1;       // improper numerators (whole * den + num)
        logic mul2;       // select the cross-product operands
        logic mul3;       // latch the cross products
        logic div_start;  // start the whole-part division
        logic div_step;   // one restoring division step
        logic div_fix;    // sign fix of quotient and remainder
        logic gcd_init;   // start Euclid
        logic gcd_start;  // start one modulo
        logic gcd_swap;   // x <= y, y <= remainder
        logic red_start;  // start a reducing division
        logic red_fix;    // latch reduced numerator or denominator
        logic red_sel;    // 0 numerator, 1 denominator
        logic finish;     // build the result
    } t_ctrl;

    typedef struct packed {
        logic is_cmp;
        logic zero_div;
        logic rem_zero;
        logic gcd_done;
        logic div_last;
    } t_stat;
endpackage
`default_nettype wire

// ----- hw/rtl/mfau_datapath.sv -----
// Datapath: operand conversion, shared multipliers, shared bit-serial divider and Euclid registers.
`default_nettype none
module mfau_datapath #(
    parameter int PART_WIDTH = mfau_pkg::PartWidthDefault
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mfau_pkg::t_ctrl                     i_ctrl,
    output mfau_pkg::t_stat                          o_stat,
    input  wire logic [1:0]                          i_cmd,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0] i_a_whole,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0] i_a_num,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0] i_a_den,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0] i_b_whole,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0] i_b_num,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0] i_b_den,
    output logic signed [mfau_pkg::WholeWidth-1:0]   o_r_whole,
    output logic signed [mfau_pkg::FracWidth-1:0]    o_r_num,
    output logic signed [mfau_pkg::FracWidth-1:0]    o_r_den,
    output logic [1:0]                               o_order,
    output logic                                     o_div_zero
);
    localparam int VW = mfau_pkg::ValWidth;
    localparam int PW = mfau_pkg::ProdWidth;
    localparam int UW = 64;

    logic [1:0]            r_cmd;
    logic signed [VW-1:0]  r_na, r_da, r_nb, r_db;
    logic signed [PW-1:0]  r_p1, r_p2;
    logic signed [PW-1:0]  r_d;
    logic                  r_n_neg, r_d_neg;
    logic [UW-1:0]         r_dvd, r_dvs, r_quo, r_rem;
    logic [UW-1:0]         r_x, r_y;
    logic signed [PW-1:0]  r_whole, r_remv, r_rnum, r_rden;
    logic [mfau_pkg::CntWidth-1:0] r_cnt;
    logic signed [VW-1:0]  r_ma, r_mb, r_mc, r_md;

    function automatic logic signed [VW-1:0] sext(input logic [mfau_pkg::FieldWidth-1:0] v);
        logic signed [PART_WIDTH-1:0] p;
        p = v[PART_WIDTH-1:0];
        return VW'(p);
    endfunction

    function automatic logic [UW-1:0] mag(input logic signed [PW-1:0] v);
        logic signed [UW-1:0] e;
        e = UW'(v);
        return e[UW-1] ? UW'(-e) : UW'(e);
    endfunction

    logic signed [VW-1:0] w_ad, w_bd;
    logic signed [VW-1:0] w_aw, w_bw;
    assign w_ad = (sext(i_a_den) == '0) ? VW'(1) : sext(i_a_den);
    assign w_bd = (sext(i_b_den) == '0) ? VW'(1) : sext(i_b_den);
    assign w_aw = sext(i_a_whole);
    assign w_bw = sext(i_b_whole);

    // One 32x32 signed multiply per operand pair per cycle.
    logic signed [2*VW-1:0] w_m1, w_m2;
    assign w_m1 = (2*VW)'(r_ma) * (2*VW)'(r_mb);
    assign w_m2 = (2*VW)'(r_mc) * (2*VW)'(r_md);

    // Restoring divide step on magnitudes.
    logic [UW:0]   w_trial;
    logic [UW-1:0] w_shrem;
    logic [UW-1:0] w_quo_next;
    assign w_shrem    = {r_rem[UW-2:0], r_dvd[UW-1]};
    assign w_trial    = {1'b0, w_shrem} - {1'b0, r_dvs};
    assign w_quo_next = {r_quo[UW-2:0], ~w_trial[UW]};

    logic signed [PW-1:0] w_q_signed, w_r_signed, w_qn_signed;
    assign w_q_signed  = (r_n_neg ^ r_d_neg) ? -PW'(r_quo) : PW'(r_quo);
    assign w_r_signed  = r_n_neg ? -PW'(r_rem) : PW'(r_rem);
    // The reduced value is taken on the last step, so it includes that step's quotient bit.
    assign w_qn_signed = (r_n_neg ^ r_d_neg) ? -PW'(w_quo_next) : PW'(w_quo_next);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_cmd;
            r_ma  <= w_aw;  r_mb <= w_ad;
            r_mc  <= w_bw;  r_md <= w_bd;
            r_da  <= w_ad;  r_db <= w_bd;
            r_na  <= sext(i_a_num);
            r_nb  <= sext(i_b_num);
        end
        if (i_ctrl.mul1) begin
            // Improper numerators; they fit in 32 bits.
            r_na <= VW'(w_m1) + r_na;
            r_nb <= VW'(w_m2) + r_nb;
        end
        if (i_ctrl.mul2) begin
            if (r_cmd == mfau_pkg::CMD_MUL) begin
                r_ma <= r_na; r_mb <= r_nb; r_mc <= r_da; r_md <= r_db;
            end else begin
                // Divide and compare both use Na*Db and Da*Nb.
                r_ma <= r_na; r_mb <= r_db; r_mc <= r_da; r_md <= r_nb;
            end
        end
        if (i_ctrl.mul3) begin
            r_p1 <= PW'(w_m1);
            r_p2 <= PW'(w_m2);
        end
        if (i_ctrl.div_start) begin
            if (i_ctrl.red_sel || i_ctrl.red_start) begin
                r_n_neg <= i_ctrl.red_sel ? r_d[PW-1] : r_remv[PW-1];
                r_d_neg <= 1'b0;
                r_dvd   <= mag(i_ctrl.red_sel ? r_d : r_remv);
                r_dvs   <= r_x;
            end else if (i_ctrl.gcd_start) begin
                r_n_neg <= 1'b0;
                r_d_neg <= 1'b0;
                r_dvd   <= r_x;
                r_dvs   <= r_y;
            end else begin
                r_d      <= r_p2;
                r_n_neg  <= r_p1[PW-1];
                r_d_neg  <= r_p2[PW-1];
                r_dvd    <= mag(r_p1);
                r_dvs    <= mag(r_p2);
            end
            r_quo <= '0;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_ctrl.div_step) begin
            if (!w_trial[UW]) begin
                r_rem <= w_trial[UW-1:0];
            end else begin
                r_rem <= w_shrem;
            end
            r_quo <= w_quo_next;
            r_dvd <= {r_dvd[UW-2:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_ctrl.div_fix) begin
            r_whole <= w_q_signed;
            r_remv  <= w_r_signed;
        end
        if (i_ctrl.gcd_init) begin
            r_x <= mag(r_d);
            r_y <= mag(r_remv);
        end
        if (i_ctrl.gcd_swap) begin
            r_x <= r_y;
            r_y <= r_rem;
        end
        if (i_ctrl.red_fix) begin
            if (i_ctrl.red_sel) r_rden <= w_qn_signed;
            else                r_rnum <= w_qn_signed;
        end
        if (i_ctrl.finish) begin
            o_order    <= mfau_pkg::ORDER_EQUAL;
            o_div_zero <= 1'b0;
            o_r_whole  <= '0;
            o_r_num    <= '0;
            o_r_den    <= mfau_pkg::FracWidth'(1);
            if (r_cmd[1]) begin
                o_order <= (r_p1 < r_p2) ? mfau_pkg::ORDER_LESS :
                           (r_p1 == r_p2) ? mfau_pkg::ORDER_EQUAL :
                           mfau_pkg::ORDER_GREATER;
            end else if (r_cmd == mfau_pkg::CMD_DIV && r_nb == '0) begin
                o_div_zero <= 1'b1;
            end else begin
                o_r_whole <= mfau_pkg::WholeWidth'(r_whole);
                if (r_remv != '0) begin
                    o_r_num <= r_rnum[mfau_pkg::FracWidth-1:0];
                    o_r_den <= r_rden[mfau_pkg::FracWidth-1:0];
                end
            end
        end
        if (!i_rst_n) r_cnt <= '0;
    end

    assign o_stat.is_cmp   = r_cmd[1];
    assign o_stat.zero_div = (r_cmd == mfau_pkg::CMD_DIV) && (r_nb == '0);
    assign o_stat.rem_zero = (r_remv == '0);
    assign o_stat.gcd_done = (r_y == '0);
    assign o_stat.div_last = (r_cnt == 6'd63);
endmodule
`default_nettype wire

// ----- hw/rtl/mfau_ctrl.sv -----
// Controller: sequences multiply, division, Euclid and reduction steps, runs the handshake.
`default_nettype none
module mfau_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output mfau_pkg::t_ctrl      o_ctrl,
    input  wire mfau_pkg::t_stat i_stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_DIVS, S_DIV, S_DFIX,
        S_GINIT, S_GTEST, S_GDIV, S_GSWAP, S_RNUM, S_RDEN, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_div_run;
    logic   r_sel;
    logic   r_kind;   // 0 whole division, 1 gcd or reduction
    logic   r_valid;

    assign o_valid = r_valid;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_ctrl = '0;
        o_ctrl.red_sel = r_sel;
        case (r_state)
            S_IDLE:  o_ctrl.load = i_valid;
            S_MUL1:  o_ctrl.mul1 = 1'b1;
            S_MUL2:  o_ctrl.mul2 = 1'b1;
            S_MUL3:  o_ctrl.mul3 = 1'b1;
            S_DIVS:  o_ctrl.div_start = 1'b1;
            S_DIV:   o_ctrl.div_step = 1'b1;
            S_DFIX:  o_ctrl.div_fix = 1'b1;
            S_GINIT: o_ctrl.gcd_init = 1'b1;
            S_GDIV: begin
                o_ctrl.gcd_start = !r_div_run;
                o_ctrl.div_start = !r_div_run;
                o_ctrl.div_step  = r_div_run;
            end
            S_GSWAP: o_ctrl.gcd_swap = 1'b1;
            S_RNUM, S_RDEN: begin
                o_ctrl.red_start = !r_div_run;
                o_ctrl.div_start = !r_div_run;
                o_ctrl.div_step  = r_div_run;
                o_ctrl.red_fix   = r_div_run && i_stat.div_last;
            end
            S_FIN:   o_ctrl.finish = 1'b1;
            default: o_ctrl = '0;
        endcase
        if (r_kind) o_ctrl.div_fix = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_run <= 1'b0;
            r_sel     <= 1'b0;
            r_kind    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_MUL3;
                S_MUL3: r_state <= (i_stat.is_cmp || i_stat.zero_div) ? S_FIN : S_DIVS;
                S_DIVS: begin
                    r_kind  <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: if (i_stat.div_last) r_state <= S_DFIX;
                S_DFIX: r_state <= S_GINIT;
                S_GINIT: begin
                    r_kind  <= 1'b1;
                    r_state <= i_stat.rem_zero ? S_FIN : S_GTEST;
                end
                S_GTEST: begin
                    r_sel   <= 1'b0;
                    r_state <= i_stat.gcd_done ? S_RNUM : S_GDIV;
                end
                S_GDIV: begin
                    if (!r_div_run) r_div_run <= 1'b1;
                    else if (i_stat.div_last) begin
                        r_div_run <= 1'b0;
                        r_state   <= S_GSWAP;
                    end
                end
                S_GSWAP: r_state <= S_GTEST;
                S_RNUM: begin
                    if (!r_div_run) r_div_run <= 1'b1;
                    else if (i_stat.div_last) begin
                        r_div_run <= 1'b0;
                        r_sel     <= 1'b1;
                        r_state   <= S_RDEN;
                    end
                end
                S_RDEN: begin
                    if (!r_div_run) r_div_run <= 1'b1;
                    else if (i_stat.div_last) begin
                        r_div_run <= 1'b0;
                        r_sel     <= 1'b0;
                        r_state   <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/mixed_fraction_arith_unit.sv -----
// Top level of the mixed fraction multiply, divide and compare unit.
//
//  channel | valid    | stall    | payload
//  input   | i_valid  | o_stall  | i_cmd, i_a_whole .. i_b_den
//  output  | o_valid  | i_stall  | o_r_whole, o_r_num, o_r_den, o_order, o_div_zero
//
// One item at a time. o_valid rises after the product steps and the finish step for compare or a
// zero divisor; an exact multiply or divide also runs the 64-step bit-serial whole-part division
// and its sign fix; a fraction adds the Euclid modulo steps, a last test and the two reducing
// divisions. The next input transfer can come in the cycle after the output transfer. Reset is
// synchronous, active low, control only.
// The result holds while the output is stalled; no new input transfer is taken until it leaves.
`default_nettype none
module mixed_fraction_arith_unit #(
    parameter int PART_WIDTH = mfau_pkg::PartWidthDefault
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    output logic                                         o_stall,
    input  wire logic [1:0]                              i_cmd,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0]  i_a_whole,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0]  i_a_num,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0]  i_a_den,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0]  i_b_whole,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0]  i_b_num,
    input  wire logic signed [mfau_pkg::FieldWidth-1:0]  i_b_den,
    output logic                                         o_valid,
    input  wire logic                                    i_stall,
    output logic signed [mfau_pkg::WholeWidth-1:0]       o_r_whole,
    output logic signed [mfau_pkg::FracWidth-1:0]        o_r_num,
    output logic signed [mfau_pkg::FracWidth-1:0]        o_r_den,
    output logic [1:0]                                   o_order,
    output logic                                         o_div_zero
);
    mfau_pkg::t_ctrl w_ctrl;
    mfau_pkg::t_stat w_stat;

    mfau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctrl  (w_ctrl),
        .i_stat  (w_stat)
    );

    mfau_datapath #(.PART_WIDTH(PART_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .i_cmd      (i_cmd),
        .i_a_whole  (i_a_whole),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_whole  (i_b_whole),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_r_whole  (o_r_whole),
        .o_r_num    (o_r_num),
        .o_r_den    (o_r_den),
        .o_order    (o_order),
        .o_div_zero (o_div_zero)
    );
endmodule
`default_nettype wire

// ----- bench/tb_mixed_fraction_arith_unit.sv -----
// Self-checking testbench for the mixed fraction multiply, divide and compare unit.
`default_nettype none
module tb_mixed_fraction_arith_unit;

    typedef struct {
        logic signed [63:0] whole;
        logic signed [47:0] num;
        logic signed [47:0] den;
        logic [1:0]         order;
        logic               dz;
    } t_frac_res;

    class t_frac_scoreboard;
        t_frac_res pending[$];
        int        errors;

        function automatic longint part(logic [15:0] v);
            part = longint'($signed(v));
        endfunction

        function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            gcd_mag = x;
        endfunction

        function automatic longint unsigned magn(longint v);
            magn = (v < 0) ? longint'(-v) : v;
        endfunction

        function void note_operands(logic [1:0] cmd, logic [15:0] aw, logic [15:0] an,
                                    logic [15:0] ad, logic [15:0] bw, logic [15:0] bn,
                                    logic [15:0] bd);
            longint na, da, nb, db, n, d, rem, g, l, r;
            t_frac_res e;
            e.whole = '0; e.num = '0; e.den = 48'd1; e.order = mfau_pkg::ORDER_EQUAL;
            e.dz = 1'b0;
            da = (part(ad) == 0) ? 1 : part(ad);
            db = (part(bd) == 0) ? 1 : part(bd);
            na = part(aw) * da + part(an);
            nb = part(bw) * db + part(bn);
            if (cmd == mfau_pkg::CMD_CMP || cmd == mfau_pkg::CMD_RSV) begin
                l = na * db;
                r = nb * da;
                e.order = (l < r) ? mfau_pkg::ORDER_LESS :
                          ((l == r) ? mfau_pkg::ORDER_EQUAL : mfau_pkg::ORDER_GREATER);
            end else begin
                if (cmd == mfau_pkg::CMD_MUL) begin
                    n = na * nb; d = da * db;
                end else begin
                    n = na * db; d = da * nb;
                end
                if (cmd == mfau_pkg::CMD_DIV && nb == 0) begin
                    e.dz = 1'b1;
                end else begin
                    e.whole = n / d;
                    rem = n % d;
                    if (rem != 0) begin
                        g = longint'(gcd_mag(magn(d), magn(rem)));
                        e.num = 48'(rem / g);
                        e.den = 48'(d / g);
                    end
                end
            end
            pending.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic signed [63:0] w, logic signed [47:0] n,
                          logic signed [47:0] d, logic [1:0] o, logic z);
            t_frac_res e;
            if (pending.size() == 0) begin
                report("result with no pending operation", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (w !== e.whole) report("r_whole", w, e.whole);
            if (n !== e.num) report("r_num", n, e.num);
            if (d !== e.den) report("r_den", d, e.den);
            if (o !== e.order) report("order", o, e.order);
            if (z !== e.dz) report("div_zero", z, e.dz);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic [1:0] i_cmd = 0;
    logic signed [15:0] i_a_whole = 0, i_a_num = 0, i_a_den = 0;
    logic signed [15:0] i_b_whole = 0, i_b_num = 0, i_b_den = 0;
    logic o_stall, o_valid, o_div_zero;
    logic signed [63:0] o_r_whole;
    logic signed [47:0] o_r_num, o_r_den;
    logic [1:0] o_order;
    t_frac_scoreboard sb = new();
    bit hold_off = 0;
    bit sent_all = 0;

    mixed_fraction_arith_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Small magnitudes keep most operations inside short Euclid runs.
    function automatic int rand_part();
        case ($urandom_range(0, 5))
            0: rand_part = int'($urandom_range(0, 65535));
            1: rand_part = $urandom_range(0, 3) == 0 ? -32768 : 32767;
            2: rand_part = 0;
            default: rand_part = int'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    task automatic send_op(int c, int aw, int an, int ad, int bw, int bn, int bd);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1; i_cmd <= 2'(c);
        i_a_whole <= 16'(aw); i_a_num <= 16'(an); i_a_den <= 16'(ad);
        i_b_whole <= 16'(bw); i_b_num <= 16'(bn); i_b_den <= 16'(bd);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_operands(i_cmd, i_a_whole, i_a_num, i_a_den, i_b_whole, i_b_num, i_b_den);
    endtask

    initial begin
        int ext[4] = '{-32768, 32767, 0, -1};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int c = 0; c < 4; c++) begin
            send_op(c, 3, 1, 4, 2, 2, 3);
            send_op(c, 1, 1, 0, -1, 0, 0);
        end
        send_op(int'(mfau_pkg::CMD_DIV), 5, 3, 7, 0, 0, 9);
        send_op(int'(mfau_pkg::CMD_DIV), 2, -4, 2, 0, 0, 1);
        send_op(int'(mfau_pkg::CMD_MUL), 4, 0, 1, 3, 0, 1);
        send_op(int'(mfau_pkg::CMD_CMP), 1, 1, -2, 1, 1, 2);
        for (int k = 0; k < 12; k++)
            send_op(int'($urandom_range(0, 3)), ext[k%4], ext[(k+1)%4], ext[(k/4)%4],
                    ext[(k+2)%4], ext[(k/2)%4], ext[(k+3)%4]);
        for (int k = 0; k < 850; k++) begin
            if (k == 300) begin
                i_valid <= 0;
                while (sb.pending.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            if (k == 500) hold_off = 1;
            send_op(int'($urandom_range(0, 3)), rand_part(), rand_part(), rand_part(),
                    rand_part(), rand_part(), rand_part());
        end
        i_valid <= 0;
        sent_all = 1;
    end

    always @(posedge i_clk) begin
        if (o_valid && !i_stall) sb.check_result(o_r_whole, o_r_num, o_r_den, o_order, o_div_zero);
    end

    // Receiver: random stall per transfer plus one long hold-off.
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                hold_off = 0;
                i_stall <= 1;
                repeat (3000) @(posedge i_clk);
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (w > 0) begin
                i_stall <= 1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 0;
            @(posedge i_clk);
            while (!(o_valid && !i_stall)) @(posedge i_clk);
        end
    end

    initial begin
        wait (sent_all);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #300000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
